@@ sv/sli_pkg.sv @@
// Package for the sorted list insert/extract block: sizes, codes and cell control type.
package sli_pkg;

  // Store depth and derived count width
  localparam int Capacity = 16;
  localparam int CntW     = $clog2(Capacity + 1);

  // Field widths fixed by the interface
  localparam int ValW  = 32;
  localparam int StatW = 2;
  localparam int OutCntW = 5;

  // Request function codes
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // Result status codes
  localparam logic [StatW-1:0] ST_INSERTED  = 2'd0;
  localparam logic [StatW-1:0] ST_EXTRACTED = 2'd1;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatW-1:0] ST_FULL      = 2'd3;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic                   ins_en;  // insert that will be stored
    logic                   ext_en;  // extract that found a match
    logic signed [ValW-1:0] value;   // request value
  } sli_op_t;

endpackage

@@ sv/sli_cell.sv @@
// One storage cell of the sorted chain: holds an entry, compares it and shifts with neighbors.
module sli_cell import sli_pkg::*; (
  input  logic                   clk_i,
  input  sli_op_t                op_i,
  input  logic                   occ_i,        // cell lies below the fill count
  input  logic                   left_lt_i,    // left neighbor is smaller (first cell: tied high)
  input  logic signed [ValW-1:0] left_entry_i,
  input  logic signed [ValW-1:0] right_entry_i,
  output logic signed [ValW-1:0] entry_o,
  output logic                   lt_o,         // occupied and smaller than request value
  output logic                   hit_o         // this cell holds the first matching entry
);

  logic signed [ValW-1:0] entry_q, entry_d;
  logic                   at_pos;
  logic                   eq;

  // Compare against the request value; the sorted order makes lt a prefix
  assign lt_o   = occ_i && (entry_q < op_i.value);
  assign eq     = occ_i && (entry_q == op_i.value);
  assign at_pos = !lt_o && left_lt_i;
  assign hit_o  = at_pos && eq;

  // Next entry: keep below the position; at and above it, insert shifts toward the free side and extract shifts back
  always_comb begin
    entry_d = entry_q;
    if (op_i.ins_en && !lt_o) begin
      entry_d = at_pos ? op_i.value : left_entry_i;
    end else if (op_i.ext_en && !lt_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ sv/sorted_list_insert_extract.sv @@
// Sorted bounded store of signed values with ordered insert and first-match extract.
// An accepted request has its result in the output register in the next cycle.
// Throughput: one request per cycle unless a result stalls; the cell chain is combinational.
// A request is taken while a result waits unless that result is stalled at the output.
// Reset (rst_ni low, asynchronous) empties the store and clears the output valid;
// entry contents are left as they are and are read only below the fill count.
module sorted_list_insert_extract import sli_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    func_i,
  input  logic signed [ValW-1:0]  value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [StatW-1:0]        status_o,
  output logic signed [ValW-1:0]  result_value_o,
  output logic [OutCntW-1:0]      entry_count_o
);

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_valid_q;
  logic [StatW-1:0]       status_q, status_d;
  logic signed [ValW-1:0] result_q, result_d;
  logic                   in_acc;
  logic                   full;
  logic                   found;
  sli_op_t                op;

  logic signed [ValW-1:0] entry [Capacity];
  logic [Capacity-1:0]    lt;
  logic [Capacity-1:0]    hit;

  // Handshake: stall only while a result is held back
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign full  = (cnt_q == CntW'(Capacity));
  assign found = |hit;

  assign op.ins_en = in_acc && (func_i == FUNC_INSERT) && !full;
  assign op.ext_en = in_acc && (func_i == FUNC_EXTRACT) && found;
  assign op.value  = value_i;

  // Cell chain
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                   left_lt;
    logic signed [ValW-1:0] left_entry;
    logic signed [ValW-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = value_i;
    end else begin : g_mid
      assign left_lt    = lt[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    sli_cell u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .occ_i         (CntW'(i) < cnt_q),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entry[i]),
      .lt_o          (lt[i]),
      .hit_o         (hit[i])
    );
  end

  // Result and count update
  always_comb begin
    cnt_d    = cnt_q;
    status_d = ST_INSERTED;
    result_d = '0;
    case (func_i)
      FUNC_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      FUNC_EXTRACT: begin
        if (found) begin
          status_d = ST_EXTRACTED;
          result_d = value_i;
          cnt_d    = cnt_q - 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_INSERTED;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q <= cnt_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      result_q <= result_d;
    end
  end

  // Output count, masked to the port width
  logic [CntW+OutCntW-1:0] cnt_ext;
  assign cnt_ext = {{OutCntW{1'b0}}, cnt_q};

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = result_q;
  assign entry_count_o  = cnt_ext[OutCntW-1:0];

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity))
    else $error("fill count above capacity");

  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.ins_en |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("stored insert did not grow the count");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func_i == FUNC_INSERT && full |=> status_q == ST_FULL && cnt_q == $past(cnt_q))
    else $error("insert into full store not flagged or changed the count");

  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one cell claims the first match");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_EXTRACTED |-> result_q == '0)
    else $error("nonzero result without extraction");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the sorted list insert/extract block.
module testbench;
  import sli_pkg::*;

  // One result of the block, field by field
  typedef struct packed {
    logic [StatW-1:0]       status;
    logic signed [ValW-1:0] value;
    logic [OutCntW-1:0]     count;
  } outcome_t;

  // One directed request; want is used only where typed is set
  typedef struct packed {
    logic                   func;
    logic signed [ValW-1:0] value;
    logic                   typed;
    outcome_t               want;
  } dir_row_t;

  localparam int DirRows    = 25;
  localparam int RandItems  = 1025;
  localparam int CalmItems  = 150;
  localparam int LongHold   = 80;
  localparam int QuietLimit = 1000;
  localparam int MaxReports = 10;

  localparam outcome_t NoWant = '0;

  // Directed requests: extremes, duplicates, misses, full store
  localparam dir_row_t DirTable [DirRows] = '{
    '{FUNC_EXTRACT, 32'sd0,          1'b1, '{ST_NOT_FOUND, 32'sd0, 5'd0}},
    '{FUNC_INSERT,  32'sh7FFFFFFF,   1'b1, '{ST_INSERTED, 32'sd0, 5'd1}},
    '{FUNC_INSERT,  32'sh80000000,   1'b1, '{ST_INSERTED, 32'sd0, 5'd2}},
    '{FUNC_INSERT,  32'sd0,          1'b0, NoWant},
    '{FUNC_INSERT,  -32'sd1,         1'b0, NoWant},
    '{FUNC_INSERT,  32'sd0,          1'b0, NoWant},
    '{FUNC_INSERT,  32'sd1,          1'b0, NoWant},
    '{FUNC_EXTRACT, 32'sh80000000,   1'b1, '{ST_EXTRACTED, 32'sh80000000, 5'd5}},
    '{FUNC_EXTRACT, 32'sd0,          1'b0, NoWant},
    '{FUNC_EXTRACT, 32'sd5,          1'b0, NoWant},
    '{FUNC_INSERT,  32'sh55555555,   1'b0, NoWant},
    '{FUNC_INSERT,  32'shAAAAAAAA,   1'b0, NoWant},
    '{FUNC_INSERT,  -32'sd2,         1'b0, NoWant},
    '{FUNC_INSERT,  32'sd2,          1'b0, NoWant},
    '{FUNC_INSERT,  32'sh7FFFFFFE,   1'b0, NoWant},
    '{FUNC_INSERT,  32'sh80000001,   1'b0, NoWant},
    '{FUNC_INSERT,  32'sd100,        1'b0, NoWant},
    '{FUNC_INSERT,  -32'sd100,       1'b0, NoWant},
    '{FUNC_INSERT,  32'sd0,          1'b0, NoWant},
    '{FUNC_INSERT,  32'sh7FFFFFFF,   1'b0, NoWant},
    '{FUNC_INSERT,  32'sh80000000,   1'b0, NoWant},
    '{FUNC_INSERT,  32'sd7,          1'b0, NoWant},
    '{FUNC_INSERT,  32'sd3,          1'b1, '{ST_FULL, 32'sd0, 5'd16}},
    '{FUNC_EXTRACT, 32'sh7FFFFFFF,   1'b1, '{ST_EXTRACTED, 32'sh7FFFFFFF, 5'd15}},
    '{FUNC_EXTRACT, -32'sd1,         1'b0, NoWant}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   func_i;
  logic signed [ValW-1:0] value_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [StatW-1:0]       status_o;
  logic signed [ValW-1:0] result_value_o;
  logic [OutCntW-1:0]     entry_count_o;

  // Sideband that travels with each request
  logic     req_typed;
  outcome_t req_want;

  // Predictor state: the sorted store and its fill count
  logic signed [ValW-1:0] sorted_vals [Capacity];
  int                     held_count;

  outcome_t pending_outcomes [$];
  int       mismatches;
  int       quiet_cycles;
  int       status_tally [4];
  int       request_total;
  int       peak_count;
  bit       calm;
  bit       hold_req;

  sorted_list_insert_extract uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .entry_count_o  (entry_count_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Apply one request to the predicted store and return its result
  function automatic outcome_t insert_or_extract(input logic f, input logic signed [ValW-1:0] v);
    outcome_t o;
    int       pos;
    int       i;
    o = '0;
    pos = 0;
    if (f == FUNC_INSERT) begin
      if (held_count >= Capacity) begin
        o.status = ST_FULL;
      end else begin
        // place in front of the first entry that is not smaller
        while (pos < held_count && sorted_vals[pos] < v) pos++;
        for (i = held_count; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[pos] = v;
        held_count++;
        o.status = ST_INSERTED;
      end
    end else begin
      while (pos < held_count && sorted_vals[pos] != v) pos++;
      if (pos >= held_count) begin
        o.status = ST_NOT_FOUND;
      end else begin
        for (i = pos; i < held_count - 1; i++) sorted_vals[i] = sorted_vals[i+1];
        held_count--;
        o.status = ST_EXTRACTED;
        o.value  = v;
      end
    end
    o.count = OutCntW'(held_count);
    return o;
  endfunction

  // Port monitor: check results against the oldest expectation, predict new requests
  always @(posedge clk_i) begin : port_monitor
    outcome_t want;
    outcome_t got;
    logic     took;
    if (rst_ni) begin
      took = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        took = 1'b1;
        got  = '{status_o, result_value_o, entry_count_o};
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result: status %0d value %0d count %0d",
                     got.status, got.value, got.count);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.status !== want.status || got.value !== want.value ||
              got.count !== want.count) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
                       want.status, want.value, want.count, got.status, got.value,
                       got.count);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        took = 1'b1;
        want = insert_or_extract(func_i, value_i);
        if (req_typed) want = req_want;
        pending_outcomes.push_back(want);
        status_tally[want.status]++;
        request_total++;
        if (held_count > peak_count) peak_count = held_count;
      end
      quiet_cycles <= took ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("sorted_list_insert_extract test failed");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin
    out_stall_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  // Sender: directed table, then random requests
  initial begin : sender
    logic                   f;
    logic signed [ValW-1:0] v;
    int                     pct_insert;
    int                     k;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_INSERT;
    value_i      = '0;
    req_typed    = 1'b0;
    req_want     = '0;
    held_count   = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    request_total = 0;
    peak_count   = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    for (k = 0; k < 4; k++) status_tally[k] = 0;
    for (k = 0; k < Capacity; k++) sorted_vals[k] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < DirRows + RandItems; k++) begin
      if (k == DirRows + RandItems - CalmItems) calm = 1'b1;
      if (k == DirRows + 250) hold_req = 1'b1;
      // one pause until the block has drained every result
      if (k == DirRows + 550) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_outcomes.size() != 0) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end

      if (k < DirRows) begin
        f = DirTable[k].func;
        v = DirTable[k].value;
        req_typed <= DirTable[k].typed;
        req_want  <= DirTable[k].want;
      end else begin
        // insert share swings so the store goes full and empty in turn
        case (((k - DirRows) / 120) % 3)
          0:       pct_insert = 85;
          1:       pct_insert = 50;
          default: pct_insert = 15;
        endcase
        f = ($urandom_range(0, 99) < pct_insert) ? FUNC_INSERT : FUNC_EXTRACT;
        if (f == FUNC_EXTRACT && held_count > 0 && $urandom_range(0, 9) < 6) begin
          v = sorted_vals[$urandom_range(0, held_count - 1)];
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2: v = $signed($urandom_range(0, 16)) - 8;
            3: begin
              case ($urandom_range(0, 3))
                0:       v = 32'sh80000000;
                1:       v = 32'sh7FFFFFFF;
                2:       v = -32'sd1;
                default: v = 32'sd0;
              endcase
            end
            default: v = $urandom;
          endcase
        end
        req_typed <= 1'b0;
        req_want  <= '0;
      end

      in_valid_i <= 1'b1;
      func_i     <= f;
      value_i    <= v;
      do @(posedge clk_i); while (in_stall_o);
    end
    in_valid_i <= 1'b0;

    // drain, then give late or extra results a chance to show up
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    // any request still waiting for its result counts as lost
    if (pending_outcomes.size() != 0) begin
      $display("%0d expected results never arrived", pending_outcomes.size());
      mismatches += pending_outcomes.size();
    end

    $display("%0d requests: %0d inserted, %0d extracted, %0d missed, %0d dropped on full",
             request_total, status_tally[ST_INSERTED], status_tally[ST_EXTRACTED],
             status_tally[ST_NOT_FOUND], status_tally[ST_FULL]);
    $display("peak fill %0d of %0d, %0d mismatches", peak_count, Capacity, mismatches);
    if (mismatches == 0) begin
      $display("sorted_list_insert_extract test passed");
    end else begin
      $display("sorted_list_insert_extract test failed");
    end
    $finish;
  end

endmodule
